[sv/mcspg_pkg.sv]
// ----------------------------------------------------------------------------
// mcspg_pkg: shared types and constants
// Mode codes, the queued command format and the coil pattern lookup.
// ----------------------------------------------------------------------------
package mcspg_pkg;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_SPEED  = 2'd1,
    MODE_STATUS = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic [1:0] REG_TICK_US = 2'd0;
  localparam logic [1:0] REG_STEPS   = 2'd1;
  localparam logic [1:0] REG_MAX_SPD = 2'd2;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd3;

  localparam logic [31:0] PERIOD_STOP = 32'h8000_0000;
  localparam logic [31:0] PERIOD_MAX  = 32'hFFFF_FFFF;
  localparam logic [28:0] DIVIDEND    = 29'd360000000;

  // Item after classification by the front end.
  typedef struct packed {
    mode_t       mode;
    logic [3:0]  channel;
    logic        in_range;
    logic        reject;
    logic        stop;
    logic        negative;
    logic [15:0] mag;
  } cmd_t;

  function automatic logic [3:0] coil_of(input logic [1:0] ph);
    logic [3:0] r;
    case (ph)
      2'd0: r = 4'b0101;
      2'd1: r = 4'b0110;
      2'd2: r = 4'b1010;
      2'd3: r = 4'b1001;
      default: r = 4'b0000;
    endcase
    return r;
  endfunction

endpackage

[sv/mcspg_front.sv]
// ----------------------------------------------------------------------------
// mcspg_front: input classification and command queue
// Decode each item, range-check speed against the limit, queue it.
// ----------------------------------------------------------------------------
module mcspg_front #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           mode,
  input  logic [3:0]           channel,
  input  logic signed [15:0]   speed_dps,
  input  logic [14:0]          speed_limit,
  output logic                 q_valid,
  input  logic                 q_ready,
  output mcspg_pkg::cmd_t      q_cmd
);
  import mcspg_pkg::*;

  localparam int unsigned DEPTH = 2;

  cmd_t        slot [DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  cmd_t        cls;
  logic [16:0] mag_wide;
  logic        push;
  logic        pop;

  always_comb begin
    mag_wide     = speed_dps[15] ? (17'h10000 - {1'b0, speed_dps}) : {1'b0, speed_dps};
    cls.mode     = mode_t'(mode);
    cls.channel  = channel;
    cls.in_range = ({28'd0, channel} < CHANNELS);
    cls.reject   = (mag_wide > {2'b00, speed_limit});
    cls.stop     = (mag_wide == 17'd0);
    cls.negative = speed_dps[15];
    cls.mag      = mag_wide[15:0];
  end

  assign in_ready = (count != 2'(DEPTH));
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'(DEPTH))
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst) (push && !pop) |=> q_valid)
    else $error("queue lost an item");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers apart when empty");

endmodule

[sv/mcspg_div.sv]
// ----------------------------------------------------------------------------
// mcspg_div: serial divider
// Restoring division of the fixed dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcspg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import mcspg_pkg::*;

  logic [28:0] rem;
  logic [28:0] dvd;
  logic [63:0] dsr;
  logic [4:0]  step;
  logic        busy;
  logic [29:0] trial;

  assign trial = {rem, dvd[28]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= '0;
        dvd      <= DIVIDEND;
        dsr      <= divisor;
        step     <= 5'd0;
        quotient <= '0;
      end else if (busy) begin
        dvd <= {dvd[27:0], 1'b0};
        if ({34'd0, trial} >= dsr) begin
          rem      <= 29'(({34'd0, trial} - dsr));
          quotient <= {quotient[30:0], 1'b1};
        end else begin
          rem      <= trial[28:0];
          quotient <= {quotient[30:0], 1'b0};
        end
        step <= step + 5'd1;
        if (step == 5'd28) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");

endmodule

[sv/mcspg_back.sv]
// ----------------------------------------------------------------------------
// mcspg_back: channel state and command execution
// Walk channels on a tick, program one channel on a set-speed, emit result.
// ----------------------------------------------------------------------------
module mcspg_back #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  mcspg_pkg::cmd_t   q_cmd,
  input  logic [15:0]       tick_us,
  input  logic [15:0]       steps,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       coil_bits,
  output logic [15:0]       enable_bits,
  output logic              accepted,
  output logic              channel_running
);
  import mcspg_pkg::*;

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_MUL1  = 6'b000100,
    S_MUL2  = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t      state;
  cmd_t        cmd;
  logic [CW-1:0] idx;
  logic [31:0] counter [CHANNELS];
  logic [31:0] period  [CHANNELS];
  logic [1:0]  phase   [CHANNELS];
  logic [1:0]  dir     [CHANNELS];
  logic [3:0]  coil    [CHANNELS];
  logic [CHANNELS-1:0] run;
  logic [31:0] prod1;
  logic [63:0] prod2;
  logic        div_start;
  logic        div_done;
  logic [31:0] quot;
  logic [31:0] cnt_next;
  logic [1:0]  ph_next;
  logic [CW-1:0] sel;

  assign sel = cmd.channel[CW-1:0];

  mcspg_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .divisor(prod2),
    .done(div_done), .quotient(quot)
  );

  assign q_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cnt_next = (counter[idx] != PERIOD_MAX) ? counter[idx] + 32'd1 : counter[idx];
    ph_next  = phase[idx] + dir[idx];
  end

  // Start the divider the cycle after the divisor product is formed.
  always_ff @(posedge clk) begin
    div_start <= !rst && (state == S_MUL2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      run       <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        counter[i] <= '0;
        period[i]  <= PERIOD_STOP;
        phase[i]   <= '0;
        dir[i]     <= DIR_STOP;
        coil[i]    <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && !out_valid) begin
            cmd <= q_cmd;
            idx <= '0;
            if (q_cmd.mode == MODE_TICK) begin
              state <= S_WALK;
            end else if (q_cmd.mode == MODE_SPEED && q_cmd.in_range
                         && !q_cmd.reject) begin
              if (q_cmd.stop) begin
                dir[q_cmd.channel[CW-1:0]]    <= DIR_STOP;
                period[q_cmd.channel[CW-1:0]] <= PERIOD_STOP;
                run[q_cmd.channel[CW-1:0]]    <= 1'b0;
                state <= S_OUT;
              end else begin
                state <= S_MUL1;
              end
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_WALK: begin
          // Advance one channel per cycle.
          if (cnt_next >= period[idx]) begin
            counter[idx] <= '0;
            phase[idx]   <= ph_next;
            coil[idx]    <= coil_of(ph_next);
          end else begin
            counter[idx] <= cnt_next;
          end
          if ({{(32-CW){1'b0}}, idx} == 32'(CHANNELS - 1)) state <= S_OUT;
          else idx <= idx + CW'(1);
        end
        S_MUL1: begin
          prod1 <= tick_us * steps;
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod2     <= {32'd0, prod1} * {48'd0, cmd.mag};
          state     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            dir[sel]    <= cmd.negative ? DIR_REV : DIR_FWD;
            period[sel] <= (prod2 == 64'd0) ? PERIOD_MAX : quot;
            run[sel]    <= 1'b1;
            state       <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result fields track live state; they are stable while out_valid is held.
  always_comb begin
    coil_bits   = '0;
    enable_bits = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      coil_bits[4*i +: 4] = coil[i];
      enable_bits[i]      = run[i];
    end
    accepted        = !(cmd.mode == MODE_SPEED && cmd.in_range && cmd.reject);
    channel_running = cmd.in_range && run[sel];
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_IDLE)
    else $error("result shown while busy");
  assert property (@(posedge clk) disable iff (rst) (state == S_OUT) |=> out_valid)
    else $error("result not raised");
  assert property (@(posedge clk) disable iff (rst) q_ready |-> !out_valid)
    else $error("took command over pending result");

endmodule

[sv/multi_channel_stepper_phase_generator_unit.sv]
// ----------------------------------------------------------------------------
// multi_channel_stepper_phase_generator_unit: stepper phase generator
// Full-step two-phase sequencer for up to 16 channels with shared limits.
// ----------------------------------------------------------------------------
// Each item gives one result. A tick walks the channels one per cycle; a
// set-speed forms the divisor with two registered multiplies and then runs
// the serial divider; stop, status and rejected items go straight to the
// result. The front end takes items into a two-entry queue, so new items are
// accepted while the back end works or a result waits, as long as the queue
// has room. The back end holds one result until taken.
module multi_channel_stepper_phase_generator_unit #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [3:0]         channel,
  input  logic signed [15:0] speed_dps,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        coil_bits,
  output logic [15:0]        enable_bits,
  output logic               accepted,
  output logic               channel_running
);
  import mcspg_pkg::*;

  logic [15:0] tick_us;
  logic [15:0] steps;
  logic [14:0] speed_limit;
  logic        q_valid;
  logic        q_ready;
  cmd_t        q_cmd;

  // Hold shared configuration; write it only while no item is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_us     <= 16'd100;
      steps       <= 16'd200;
      speed_limit <= 15'd900;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICK_US: tick_us     <= cfg_data;
        REG_STEPS:   steps       <= cfg_data;
        REG_MAX_SPD: speed_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  mcspg_front #(.CHANNELS(CHANNELS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .channel(channel), .speed_dps(speed_dps),
    .speed_limit(speed_limit), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  mcspg_back #(.CHANNELS(CHANNELS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .tick_us(tick_us), .steps(steps), .out_valid(out_valid),
    .out_ready(out_ready), .coil_bits(coil_bits), .enable_bits(enable_bits),
    .accepted(accepted), .channel_running(channel_running)
  );

endmodule
